/* design/xup_pkg.sv */
// shared types and constants for the xorshift page offset generator
package xup_pkg;

	localparam int unsigned ACTION_W = 2;
	localparam int unsigned RANGE_W  = 53;
	localparam int unsigned WORD_W   = 64;
	localparam int unsigned HALF_W   = 32;
	localparam int unsigned CNT_W    = 6;

	localparam logic [ACTION_W-1:0] ACT_DRAW = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_MIX  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_SEED = 2'd2;

	localparam logic [WORD_W-1:0] MIX_MUL  = 64'h2545F4914F6CDD1D;
	localparam logic [WORD_W-1:0] GOLD_MUL = 64'h9E3779B97F4A7C15;
	localparam logic [WORD_W-1:0] HALF_MUL = 64'hC2B2AE3D27D4EB4F;
	localparam logic [WORD_W-1:0] RESET_A  = 64'h1234567890ABCDEF;
	localparam logic [WORD_W-1:0] RESET_B  = 64'hFEDCBA0987654321;

	localparam logic [CNT_W-1:0] DIV_LAST = 6'd63;
	localparam logic [1:0]       MUL_LAST = 2'd3;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_CAPTURE,
		OP_RES_CLR,
		OP_SEED,
		OP_STEP,
		OP_MUL,
		OP_DIV_LD_MAX,
		OP_DIV_LD_R,
		OP_DIV_STEP,
		OP_SET_LIM,
		OP_AP_R,
		OP_AP_GOLD,
		OP_AP_HALF,
		OP_AP_OUT,
		OP_OUT_WR
	} xup_op_t;

	typedef enum logic [1:0] {
		MS_MIX,
		MS_GOLD,
		MS_HALF,
		MS_PAGE
	} xup_mul_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_LIM_INIT,
		ST_LIM_DIV,
		ST_LIM_SET,
		ST_STEP,
		ST_MIX_MUL,
		ST_AP_R,
		ST_CHECK,
		ST_R_INIT,
		ST_R_DIV,
		ST_PG_MUL,
		ST_AP_OUT,
		ST_GOLD_MUL,
		ST_AP_GOLD,
		ST_HALF_MUL,
		ST_AP_HALF,
		ST_SEED,
		ST_DONE
	} xup_state_t;

	typedef struct packed {
		xup_op_t      op;
		xup_mul_sel_t mul_sel;
		logic [1:0]   mul_phase;
	} xup_cmd_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic                range_zero;
		logic                reject;
		logic                out_free;
	} xup_status_t;

endpackage

/* design/xup_req_if.sv */
// request channel: one item per draw, mix or seed load
interface xup_req_if import xup_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [RANGE_W-1:0]  range_pages;
	logic [WORD_W-1:0]   entropy_value;
	logic [WORD_W-1:0]   timestamp;
	logic [WORD_W-1:0]   seed_low;
	logic [WORD_W-1:0]   seed_high;

	modport source (
		output valid, action, range_pages, entropy_value, timestamp, seed_low, seed_high,
		input  ready
	);
	modport sink (
		input  valid, action, range_pages, entropy_value, timestamp, seed_low, seed_high,
		output ready
	);
endinterface

/* design/xup_rsp_if.sv */
// response channel: one offset item per request
interface xup_rsp_if import xup_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] offset_bytes;

	modport source (
		output valid, offset_bytes,
		input  ready
	);
	modport sink (
		input  valid, offset_bytes,
		output ready
	);
endinterface

/* design/xup_ctrl.sv */
// sequencing state machine for the page offset generator
module xup_ctrl import xup_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  xup_status_t status,
	output xup_cmd_t    cmd
);

	xup_state_t        state_q;
	xup_state_t        state_next;
	logic [CNT_W-1:0]  cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_next;
			// counter restarts whenever the state changes
			if (state_next != state_q) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				unique case (status.action)
					ACT_DRAW: state_next = status.range_zero ? ST_DONE : ST_LIM_INIT;
					ACT_MIX:  state_next = ST_GOLD_MUL;
					ACT_SEED: state_next = ST_SEED;
					default:  state_next = ST_DONE;
				endcase
			end
			ST_LIM_INIT: state_next = ST_LIM_DIV;
			ST_LIM_DIV: begin
				if (cnt_q == DIV_LAST) state_next = ST_LIM_SET;
			end
			ST_LIM_SET: state_next = ST_STEP;
			ST_STEP: state_next = (status.action == ACT_MIX) ? ST_DONE : ST_MIX_MUL;
			ST_MIX_MUL: begin
				if (cnt_q[1:0] == MUL_LAST) state_next = ST_AP_R;
			end
			ST_AP_R: state_next = ST_CHECK;
			ST_CHECK: state_next = status.reject ? ST_STEP : ST_R_INIT;
			ST_R_INIT: state_next = ST_R_DIV;
			ST_R_DIV: begin
				if (cnt_q == DIV_LAST) state_next = ST_PG_MUL;
			end
			ST_PG_MUL: begin
				if (cnt_q[1:0] == MUL_LAST) state_next = ST_AP_OUT;
			end
			ST_AP_OUT: state_next = ST_DONE;
			ST_GOLD_MUL: begin
				if (cnt_q[1:0] == MUL_LAST) state_next = ST_AP_GOLD;
			end
			ST_AP_GOLD: state_next = ST_HALF_MUL;
			ST_HALF_MUL: begin
				if (cnt_q[1:0] == MUL_LAST) state_next = ST_AP_HALF;
			end
			ST_AP_HALF: state_next = ST_STEP;
			ST_SEED: state_next = ST_DONE;
			ST_DONE: begin
				if (status.out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op        = OP_NOP;
		cmd.mul_sel   = MS_MIX;
		cmd.mul_phase = cnt_q[1:0];
		in_ready      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_CAPTURE;
			end
			ST_DISPATCH: cmd.op = OP_RES_CLR;
			ST_LIM_INIT: cmd.op = OP_DIV_LD_MAX;
			ST_LIM_DIV:  cmd.op = OP_DIV_STEP;
			ST_LIM_SET:  cmd.op = OP_SET_LIM;
			ST_STEP:     cmd.op = OP_STEP;
			ST_MIX_MUL: begin
				cmd.op      = OP_MUL;
				cmd.mul_sel = MS_MIX;
			end
			ST_AP_R:     cmd.op = OP_AP_R;
			ST_CHECK:    cmd.op = OP_NOP;
			ST_R_INIT:   cmd.op = OP_DIV_LD_R;
			ST_R_DIV:    cmd.op = OP_DIV_STEP;
			ST_PG_MUL: begin
				cmd.op      = OP_MUL;
				cmd.mul_sel = MS_PAGE;
			end
			ST_AP_OUT:   cmd.op = OP_AP_OUT;
			ST_GOLD_MUL: begin
				cmd.op      = OP_MUL;
				cmd.mul_sel = MS_GOLD;
			end
			ST_AP_GOLD:  cmd.op = OP_AP_GOLD;
			ST_HALF_MUL: begin
				cmd.op      = OP_MUL;
				cmd.mul_sel = MS_HALF;
			end
			ST_AP_HALF:  cmd.op = OP_AP_HALF;
			ST_SEED:     cmd.op = OP_SEED;
			ST_DONE: begin
				if (status.out_free) cmd.op = OP_OUT_WR;
			end
			default:     cmd.op = OP_NOP;
		endcase
	end

endmodule

/* design/xup_dpath.sv */
// generator state, shared 32x32 multiplier, bit-serial remainder unit and output register
module xup_dpath import xup_pkg::*; #(
	parameter int unsigned PAGE_BYTES = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  xup_cmd_t            cmd,
	output xup_status_t         status,
	input  logic [ACTION_W-1:0] action,
	input  logic [RANGE_W-1:0]  range_pages,
	input  logic [WORD_W-1:0]   entropy_value,
	input  logic [WORD_W-1:0]   timestamp,
	input  logic [WORD_W-1:0]   seed_low,
	input  logic [WORD_W-1:0]   seed_high,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [WORD_W-1:0]   out_data
);

	localparam logic [WORD_W-1:0] PAGE_CONST = WORD_W'(PAGE_BYTES);

	// captured item
	logic [ACTION_W-1:0] act_q;
	logic [RANGE_W-1:0]  range_q;
	logic [WORD_W-1:0]   val_q;
	logic [WORD_W-1:0]   stamp_q;
	logic [WORD_W-1:0]   seed_lo_q;
	logic [WORD_W-1:0]   seed_hi_q;

	logic [WORD_W-1:0]   gen_a_q;
	logic [WORD_W-1:0]   gen_b_q;
	logic [WORD_W-1:0]   s_q;
	logic [WORD_W-1:0]   prod_q;
	logic [WORD_W-1:0]   acc_q;
	logic [WORD_W-1:0]   lim_q;
	logic [WORD_W-1:0]   r_q;
	logic [WORD_W-1:0]   dvd_q;
	logic [RANGE_W-1:0]  rem_q;
	logic [WORD_W-1:0]   res_q;
	logic                out_valid_q;
	logic [WORD_W-1:0]   out_data_q;

	// generator step
	logic [WORD_W-1:0] x1, x2, x3, nb, s_mix;

	always_comb begin
		x1    = gen_a_q ^ (gen_a_q << 23);
		x2    = x1 ^ (x1 >> 17);
		x3    = x2 ^ gen_b_q ^ (gen_b_q >> 26);
		nb    = x3 + gen_b_q;
		s_mix = nb ^ (nb >> 17);
	end

	// multiplier operands, low 64 bits built from three partial products
	logic [WORD_W-1:0] op_a, op_b;
	logic [HALF_W-1:0] ma, mb;

	always_comb begin
		case (cmd.mul_sel)
			MS_MIX: begin
				op_a = s_q;
				op_b = MIX_MUL;
			end
			MS_GOLD: begin
				op_a = val_q;
				op_b = GOLD_MUL;
			end
			MS_HALF: begin
				op_a = {{HALF_W{1'b0}}, val_q[WORD_W-1:HALF_W]};
				op_b = HALF_MUL;
			end
			default: begin
				op_a = {{(WORD_W-RANGE_W){1'b0}}, rem_q};
				op_b = PAGE_CONST;
			end
		endcase
		case (cmd.mul_phase)
			2'd1: begin
				ma = op_a[HALF_W-1:0];
				mb = op_b[WORD_W-1:HALF_W];
			end
			2'd2: begin
				ma = op_a[WORD_W-1:HALF_W];
				mb = op_b[HALF_W-1:0];
			end
			default: begin
				ma = op_a[HALF_W-1:0];
				mb = op_b[HALF_W-1:0];
			end
		endcase
	end

	// restoring remainder step
	logic [RANGE_W:0] div_t;
	logic [RANGE_W:0] div_d;
	logic             div_ge;

	always_comb begin
		div_t  = {rem_q, dvd_q[WORD_W-1]};
		div_d  = {1'b0, range_q};
		div_ge = div_t >= div_d;
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: begin
				act_q     <= action;
				range_q   <= range_pages;
				val_q     <= entropy_value;
				stamp_q   <= timestamp;
				seed_lo_q <= seed_low;
				seed_hi_q <= seed_high;
			end
			OP_RES_CLR: res_q <= '0;
			OP_STEP:    s_q   <= s_mix;
			OP_MUL: begin
				prod_q <= {{HALF_W{1'b0}}, ma} * {{HALF_W{1'b0}}, mb};
				case (cmd.mul_phase)
					2'd0:    acc_q <= '0;
					2'd1:    acc_q <= prod_q;
					default: acc_q <= acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
				endcase
			end
			OP_DIV_LD_MAX: begin
				dvd_q <= '1;
				rem_q <= '0;
			end
			OP_DIV_LD_R: begin
				dvd_q <= r_q;
				rem_q <= '0;
			end
			OP_DIV_STEP: begin
				dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
				rem_q <= div_ge ? RANGE_W'(div_t - div_d) : div_t[RANGE_W-1:0];
			end
			// all-ones minus remainder is its complement
			OP_SET_LIM: lim_q <= ~{{(WORD_W-RANGE_W){1'b0}}, rem_q};
			OP_AP_R:    r_q   <= acc_q ^ (acc_q >> 31);
			OP_AP_OUT:  res_q <= acc_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_a_q <= RESET_A;
			gen_b_q <= RESET_B;
		end else begin
			case (cmd.op)
				OP_STEP: begin
					gen_a_q <= gen_b_q;
					gen_b_q <= nb;
				end
				OP_AP_GOLD: gen_a_q <= gen_a_q ^ acc_q;
				OP_AP_HALF: gen_b_q <= gen_b_q ^ acc_q ^ stamp_q;
				OP_SEED: begin
					if (seed_lo_q == '0 && seed_hi_q == '0) begin
						gen_a_q <= GOLD_MUL;
						gen_b_q <= HALF_MUL ^ stamp_q;
					end else begin
						gen_a_q <= seed_lo_q;
						gen_b_q <= seed_hi_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_OUT_WR) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT_WR) out_data_q <= res_q;
	end

	always_comb begin
		status.action     = act_q;
		status.range_zero = (range_q == '0);
		status.reject     = (r_q >= lim_q);
		status.out_free   = !out_valid_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* design/xorshift_uniform_page_offset.sv */
// top level of the xorshift page offset generator
//
// usage: each request item on req carries an action (draw, mix entropy, load
// seed) and its operands; exactly one item comes back on rsp with offset_bytes,
// a page-aligned offset for a draw and zero for every other action.
// one request is worked on at a time; req.ready is high only while idle.
// steps from acceptance to the response being offered:
//   draw with zero range, unused action: dispatch only
//   load seed: the seed is loaded into the generator state
//   mix entropy: two multiplies and one generator step
//   draw: a generator step and multiply per attempt, rejected ones included, and
//   two bit-serial remainder passes; all multiplies share one 32x32 unit
// the next request is taken only once the response to the last is offered.
// the response sits in an output register; a new request is taken while it
// waits, and the block holds in its final state if rsp stalls with a response
// still pending.
// reset reloads the fixed generator state and drops any pending response.
module xorshift_uniform_page_offset import xup_pkg::*; #(
	parameter int unsigned PAGE_BYTES = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	xup_req_if.sink   req,
	xup_rsp_if.source rsp
);

	xup_cmd_t    cmd;
	xup_status_t status;

	xup_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.status   (status),
		.cmd      (cmd)
	);

	xup_dpath #(
		.PAGE_BYTES (PAGE_BYTES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.action        (req.action),
		.range_pages   (req.range_pages),
		.entropy_value (req.entropy_value),
		.timestamp     (req.timestamp),
		.seed_low      (req.seed_low),
		.seed_high     (req.seed_high),
		.out_ready     (rsp.ready),
		.out_valid     (rsp.valid),
		.out_data      (rsp.offset_bytes)
	);

endmodule
